// ===== design/zncc_pkg.sv =====
// Shared types and constants for the ZNCC template matcher.
package zncc_pkg;

  localparam int DIM_W  = 11;   // source dimension register width
  localparam int TDIM_W = 5;    // template dimension register width
  localparam int N_W    = 10;   // window pixel count
  localparam int SUM_W  = 18;   // sum of pixels over a window
  localparam int SQ_W   = 26;   // sum of squares / cross products
  localparam int V_W    = 36;   // variance-like terms and numerator magnitude
  localparam int MB_W   = 18;   // narrow multiplier operand
  localparam int D2_W   = 72;   // squared denominator
  localparam int ACC_W  = 104;  // square-root search accumulators
  localparam int Q_W    = 16;

  localparam logic [1:0] REG_SRC_W  = 2'd0;
  localparam logic [1:0] REG_SRC_H  = 2'd1;
  localparam logic [1:0] REG_TMPL_W = 2'd2;
  localparam logic [1:0] REG_TMPL_H = 2'd3;

  localparam logic CMD_TMPL = 1'b0;
  localparam logic CMD_SRC  = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] pixel;
  } pix_t;

  typedef struct packed {
    logic signed [15:0] score;
    logic [9:0]         win_row;
    logic [9:0]         win_col;
    logic               frame_end;
  } score_t;

endpackage

// ===== design/zncc_template_match_top.sv =====
// ZNCC template matcher: template and line stores, window scan and score sequencer.
// Usage:
//   Pixels arrive on the pix channel (pix_valid / pix_stall / pix_data). cmd 0 loads
//   the next template pixel in raster order; cmd 1 streams the next source pixel.
//   Scores leave on the score channel (score_valid / score_stall / score_data),
//   one per source pixel that completes a window while a template is loaded.
//   Template pixels and source pixels that complete no window leave the sequencer idle.
//   A completing pixel keeps the sequencer busy while it reads the window, one window
//   pixel per cycle through the single read port of the line store, works on the
//   shared 36x18 multiplier, and runs the square-root/divide search, one score bit
//   per pass through S_SRCH0 and S_SRCH1, plus one more probe when the full-scale
//   probe runs; the search is skipped when a variance is zero.
//   The score goes to an output register; the next pixel is accepted while it
//   waits. If the receiver stalls and a second score is ready, the sequencer
//   holds it and pix_stall stays high until the first transfer completes.
//   Reset restores full-size dimensions and drops the loaded template. Any
//   register write over APB restarts template loading and the source position.
//   Stores need no clearing pass; reads only hit entries already written.
module zncc_template_match_top #(
  parameter int MAX_SRC_W  = 1024,
  parameter int MAX_SRC_H  = 1024,
  parameter int MAX_TMPL_W = 16,
  parameter int MAX_TMPL_H = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pix_valid,
  output logic                 pix_stall,
  input  zncc_pkg::pix_t       pix_data,
  output logic                 score_valid,
  input  logic                 score_stall,
  output zncc_pkg::score_t     score_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import zncc_pkg::*;

  localparam int COL_AW = $clog2(MAX_SRC_W);
  localparam int ROW_AW = (MAX_TMPL_H > 1) ? $clog2(MAX_TMPL_H) : 1;
  localparam int RS     = ROW_AW + 2;
  localparam int TAW    = $clog2(MAX_TMPL_W * MAX_TMPL_H);
  localparam int LDEPTH = 2 ** (ROW_AW + COL_AW);
  localparam int TDEPTH = MAX_TMPL_W * MAX_TMPL_H;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ACC    = 3'd1;
  localparam logic [2:0] S_ACCEND = 3'd2;
  localparam logic [2:0] S_MUL    = 3'd3;
  localparam logic [2:0] S_SRCH0  = 3'd4;
  localparam logic [2:0] S_SRCH1  = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  // configuration
  logic [DIM_W-1:0]  src_w, src_h;
  logic [TDIM_W-1:0] tw, th;
  logic              cfg_wr;
  logic [DIM_W-1:0]  wd11;
  logic [TDIM_W-1:0] wd5;

  // position / template state
  logic [DIM_W-1:0]  row, col;
  logic [ROW_AW-1:0] rslot;
  logic [N_W-1:0]    tcount;
  logic              tready;
  logic [SUM_W-1:0]  tsum, tacc_s;
  logic [SQ_W-1:0]   tsq, tacc_q;

  logic [2:0] state;

  // memories
  logic [7:0] line_mem [LDEPTH];
  logic [7:0] tmpl_mem [TDEPTH];
  logic [7:0] line_q, tmpl_q;
  logic [ROW_AW+COL_AW-1:0] l_waddr, l_raddr;
  logic [TAW-1:0]           t_waddr, t_raddr;
  logic                     l_we, t_we;

  // scan
  logic [TDIM_W-1:0] k, m;
  logic [ROW_AW-1:0] sslot;
  logic [DIM_W-1:0]  lcol, left;
  logic [N_W-1:0]    ti;
  logic              rd_vld;
  logic [SUM_W-1:0]  sx;
  logic [SQ_W-1:0]   sxx, sxt;
  logic [9:0]        win_row, win_col;
  logic              fend;

  // arithmetic
  logic [3:0]        mstep;
  logic [V_W-1:0]    ma;
  logic [MB_W-1:0]   mb;
  logic [V_W+MB_W-1:0] mprod;
  logic [V_W-1:0]    a0, vx, vt, mag;
  logic              neg, zden;
  logic [D2_W-1:0]   den2;
  logic [D2_W-1:0]   lsq;
  logic [ACC_W-1:0]  p_acc, d_acc, tsumr, cand;
  logic [3:0]        bidx;
  logic              fin;
  logic [Q_W-1:0]    q, qn;
  logic              ok;

  logic [N_W-1:0]    n_tot;
  logic              accept;
  logic              is_win;
  logic [N_W-1:0]    eff_cnt;
  logic [SUM_W-1:0]  ns;
  logic [SQ_W-1:0]   nq;
  logic [RS-1:0]     top_tmp;
  logic signed [15:0] score_val;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign n_tot   = N_W'(tw) * N_W'(th);
  assign accept  = pix_valid & ~pix_stall;
  assign pix_stall = (state != S_IDLE);

  // write data fields for the clamp: zero acts as one, above the maximum acts as the maximum
  always_comb begin
    wd11 = pwdata[DIM_W-1:0];
    wd5  = pwdata[TDIM_W-1:0];
  end

  always_comb begin
    case (paddr[3:2])
      REG_SRC_W:  prdata = 32'(src_w);
      REG_SRC_H:  prdata = 32'(src_h);
      REG_TMPL_W: prdata = 32'(tw);
      REG_TMPL_H: prdata = 32'(th);
      default:    prdata = '0;
    endcase
  end

  // template load bookkeeping
  always_comb begin
    eff_cnt = (tready || tcount >= n_tot) ? '0 : tcount;
    ns = ((eff_cnt == '0) ? '0 : tacc_s) + SUM_W'(pix_data.pixel);
    nq = ((eff_cnt == '0) ? '0 : tacc_q) + SQ_W'(pix_data.pixel * pix_data.pixel);
  end

  assign is_win = tready && (12'(row) + 12'd1 >= 12'(th)) && (12'(col) + 12'd1 >= 12'(tw));

  always_comb begin
    top_tmp = RS'(rslot) + RS'(MAX_TMPL_H) - RS'(th) + RS'(1);
    if (top_tmp >= RS'(MAX_TMPL_H)) top_tmp = top_tmp - RS'(MAX_TMPL_H);
  end

  // memory ports
  assign l_we    = accept && (pix_data.cmd == CMD_SRC);
  assign t_we    = accept && (pix_data.cmd == CMD_TMPL);
  assign l_waddr = {rslot, COL_AW'(col)};
  assign l_raddr = {sslot, COL_AW'(lcol)};
  assign t_waddr = TAW'(eff_cnt);
  assign t_raddr = TAW'(ti);

  always_ff @(posedge clk) begin
    if (l_we) line_mem[l_waddr] <= pix_data.pixel;
    line_q <= line_mem[l_raddr];
  end

  always_ff @(posedge clk) begin
    if (t_we) tmpl_mem[t_waddr] <= pix_data.pixel;
    tmpl_q <= tmpl_mem[t_raddr];
  end

  // shared multiplier operand select
  always_comb begin
    case (mstep)
      4'd0:    begin ma = V_W'(sxx);  mb = MB_W'(n_tot); end
      4'd1:    begin ma = V_W'(sx);   mb = MB_W'(sx);    end
      4'd2:    begin ma = V_W'(tsq);  mb = MB_W'(n_tot); end
      4'd3:    begin ma = V_W'(tsum); mb = MB_W'(tsum);  end
      4'd4:    begin ma = V_W'(sxt);  mb = MB_W'(n_tot); end
      4'd5:    begin ma = V_W'(sx);   mb = MB_W'(tsum);  end
      4'd6:    begin ma = vt;         mb = vx[MB_W-1:0]; end
      4'd7:    begin ma = vt;         mb = vx[V_W-1:MB_W]; end
      4'd8:    begin ma = mag;        mb = mag[MB_W-1:0]; end
      4'd9:    begin ma = mag;        mb = mag[V_W-1:MB_W]; end
      default: begin ma = '0;         mb = '0;           end
    endcase
  end

  always_ff @(posedge clk) begin
    mprod <= ma * mb;
  end

  // one bit of the root/divide search: den2*(q+2^b)^2 against mag^2 * 2^30
  always_comb begin
    cand = tsumr + (ACC_W'(den2) << (2 * bidx));
    ok   = (cand <= (ACC_W'(lsq) << 30));
    qn   = ok ? q + (Q_W'(1) << bidx) : q;
  end

  always_comb begin
    if (zden)      score_val = '0;
    else if (neg)  score_val = -$signed(q);
    else if (q > 16'd32767) score_val = 16'sd32767;
    else           score_val = $signed(q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_w  <= DIM_W'(MAX_SRC_W > 1024 ? 1024 : MAX_SRC_W);
      src_h  <= DIM_W'(MAX_SRC_H > 1024 ? 1024 : MAX_SRC_H);
      tw     <= TDIM_W'(MAX_TMPL_W > 16 ? 16 : MAX_TMPL_W);
      th     <= TDIM_W'(MAX_TMPL_H > 16 ? 16 : MAX_TMPL_H);
      row    <= '0;
      col    <= '0;
      rslot  <= '0;
      tcount <= '0;
      tready <= 1'b0;
      state  <= S_IDLE;
      rd_vld <= 1'b0;
      score_valid <= 1'b0;
    end else begin
      rd_vld <= (state == S_ACC);
      // S_DONE sets score_valid itself when it loads a new score
      if (score_valid && !score_stall && state != S_DONE) score_valid <= 1'b0;

      if (cfg_wr) begin
        case (paddr[3:2])
          REG_SRC_W:  src_w <= (wd11 == '0) ? DIM_W'(1) :
                               (int'(wd11) > MAX_SRC_W) ? DIM_W'(MAX_SRC_W) : wd11;
          REG_SRC_H:  src_h <= (wd11 == '0) ? DIM_W'(1) :
                               (int'(wd11) > MAX_SRC_H) ? DIM_W'(MAX_SRC_H) : wd11;
          REG_TMPL_W: tw <= (wd5 == '0) ? TDIM_W'(1) :
                            (int'(wd5) > MAX_TMPL_W) ? TDIM_W'(MAX_TMPL_W) : wd5;
          REG_TMPL_H: th <= (wd5 == '0) ? TDIM_W'(1) :
                            (int'(wd5) > MAX_TMPL_H) ? TDIM_W'(MAX_TMPL_H) : wd5;
          default: ;
        endcase
        tcount <= '0;
        tready <= 1'b0;
        row    <= '0;
        col    <= '0;
        rslot  <= '0;
      end

      case (state)
        S_IDLE: begin
          if (accept && pix_data.cmd == CMD_TMPL) begin
            tacc_s <= ns;
            tacc_q <= nq;
            tcount <= eff_cnt + N_W'(1);
            tready <= (eff_cnt + N_W'(1) == n_tot);
            if (eff_cnt + N_W'(1) == n_tot) begin
              tsum   <= ns;
              tsq    <= nq;
            end
          end else if (accept) begin
            if (is_win) begin
              state   <= S_ACC;
              sslot   <= ROW_AW'(top_tmp);
              left    <= col + DIM_W'(1) - DIM_W'(tw);
              lcol    <= col + DIM_W'(1) - DIM_W'(tw);
              win_row <= 10'(row + DIM_W'(1) - DIM_W'(th));
              win_col <= 10'(col + DIM_W'(1) - DIM_W'(tw));
              fend    <= (row + DIM_W'(1) == src_h) && (col + DIM_W'(1) == src_w);
              k  <= '0;
              m  <= '0;
              ti <= '0;
              sx  <= '0;
              sxx <= '0;
              sxt <= '0;
            end
            if (col + DIM_W'(1) >= src_w) begin
              col <= '0;
              if (row + DIM_W'(1) >= src_h) begin
                row   <= '0;
                rslot <= '0;
              end else begin
                row   <= row + DIM_W'(1);
                rslot <= (rslot == ROW_AW'(MAX_TMPL_H - 1)) ? '0 : rslot + ROW_AW'(1);
              end
            end else begin
              col <= col + DIM_W'(1);
            end
          end
        end

        S_ACC: begin
          ti <= ti + N_W'(1);
          if (k == tw - TDIM_W'(1)) begin
            k     <= '0;
            lcol  <= left;
            m     <= m + TDIM_W'(1);
            sslot <= (sslot == ROW_AW'(MAX_TMPL_H - 1)) ? '0 : sslot + ROW_AW'(1);
            if (m == th - TDIM_W'(1)) state <= S_ACCEND;
          end else begin
            k    <= k + TDIM_W'(1);
            lcol <= lcol + DIM_W'(1);
          end
        end

        S_ACCEND: begin
          state <= S_MUL;
          mstep <= '0;
        end

        S_MUL: begin
          mstep <= mstep + 4'd1;
          case (mstep)
            4'd1, 4'd3, 4'd5: a0 <= mprod[V_W-1:0];
            4'd2: vx <= (a0 >= mprod[V_W-1:0]) ? a0 - mprod[V_W-1:0] : mprod[V_W-1:0] - a0;
            4'd4: vt <= (a0 >= mprod[V_W-1:0]) ? a0 - mprod[V_W-1:0] : mprod[V_W-1:0] - a0;
            4'd6: begin
              neg <= mprod[V_W-1:0] > a0;
              mag <= (mprod[V_W-1:0] > a0) ? mprod[V_W-1:0] - a0 : a0 - mprod[V_W-1:0];
            end
            4'd7: den2 <= D2_W'(mprod);
            4'd8: den2 <= den2 + (D2_W'(mprod) << MB_W);
            4'd9: lsq <= D2_W'(mprod);
            4'd10: begin
              lsq   <= lsq + (D2_W'(mprod) << MB_W);
              zden  <= (vx == '0) || (vt == '0);
              q     <= '0;
              p_acc <= '0;
              d_acc <= '0;
              bidx  <= 4'd14;
              fin   <= 1'b0;
              state <= ((vx == '0) || (vt == '0)) ? S_DONE : S_SRCH0;
            end
            default: ;
          endcase
        end

        S_SRCH0: begin
          tsumr <= p_acc + (d_acc << (bidx + 4'd1));
          state <= S_SRCH1;
        end

        S_SRCH1: begin
          q <= qn;
          if (ok) begin
            p_acc <= cand;
            d_acc <= d_acc + (ACC_W'(den2) << bidx);
          end
          if (fin) begin
            state <= S_DONE;
          end else if (bidx == 4'd0) begin
            // full scale needs one more probe at +1.0
            if (qn == 16'd32767) begin
              fin   <= 1'b1;
              state <= S_SRCH0;
            end else begin
              state <= S_DONE;
            end
          end else begin
            bidx  <= bidx - 4'd1;
            state <= S_SRCH0;
          end
        end

        S_DONE: begin
          if (!score_valid || !score_stall) begin
            score_valid          <= 1'b1;
            score_data.score     <= score_val;
            score_data.win_row   <= win_row;
            score_data.win_col   <= win_col;
            score_data.frame_end <= fend;
            state                <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase

      if (rd_vld) begin
        sx  <= sx + SUM_W'(line_q);
        sxx <= sxx + SQ_W'(line_q * line_q);
        sxt <= sxt + SQ_W'(line_q * tmpl_q);
      end
    end
  end

endmodule

// ===== tb/sv/zncc_template_match_top_tb.sv =====
// Self-checking testbench for the ZNCC template matcher: directed table plus random phases.
`timescale 1ns / 1ps
module zncc_template_match_top_tb;
  import zncc_pkg::*;

  typedef struct {
    pix_t               p;
    bit                 fixed;   // score typed in the table
    logic signed [15:0] sc;
  } stim_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        pix_valid = 1'b0;
  logic        pix_stall;
  pix_t        pix_data = '0;
  logic        score_valid;
  logic        score_stall = 1'b0;
  score_t      score_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  zncc_template_match_top dut (
    .clk(clk), .rst(rst),
    .pix_valid(pix_valid), .pix_stall(pix_stall), .pix_data(pix_data),
    .score_valid(score_valid), .score_stall(score_stall), .score_data(score_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  stim_t  pix_q[$];
  score_t score_q[$];
  stim_t  cur;
  int     errors = 0;
  int     items_pushed = 0;
  int     scores_seen = 0;
  int     hold_left = 0;
  bit     hold_done = 0;
  bit     idle_on = 1;

  // predictor state
  logic [7:0] tpl_mem [256];
  logic [7:0] line_mem [16*1024];
  int unsigned tpl_cnt, row_pos, col_pos, sw, sh, tw, th;
  bit          tpl_ok;
  longint unsigned tpl_sum, tpl_sq;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned mx);
    if (v == 0) return 1;
    if (v > mx) return mx;
    return v;
  endfunction

  function automatic logic signed [15:0] zncc(longint unsigned n, longint unsigned sx,
                                              longint unsigned sxx, longint unsigned sxt);
    longint unsigned vx, vt, pos, neg, mag;
    logic [127:0] den2, lim;
    int unsigned lo, hi, mid;
    bit negv;
    vx = (n*sxx >= sx*sx) ? n*sxx - sx*sx : sx*sx - n*sxx;
    vt = (n*tpl_sq >= tpl_sum*tpl_sum) ? n*tpl_sq - tpl_sum*tpl_sum
                                         : tpl_sum*tpl_sum - n*tpl_sq;
    pos = n*sxt;
    neg = sx*tpl_sum;
    negv = neg > pos;
    mag = negv ? neg - pos : pos - neg;
    if (vx == 0 || vt == 0) return 16'sd0;
    den2 = 128'(vx) * 128'(vt);
    lim = (128'(mag) * 128'(mag)) << 30;
    lo = 0;
    hi = 32768;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      if (den2 * 128'(longint'(mid) * mid) <= lim) lo = mid;
      else hi = mid - 1;
    end
    if (negv) return 16'(-int'(lo));
    return (lo > 32767) ? 16'sd32767 : 16'(lo);
  endfunction

  task automatic predict_pixel(stim_t s);
    int unsigned total, top, left, m, k;
    longint unsigned sx, sxx, sxt, x, t;
    score_t res;
    total = tw * th;
    if (s.p.cmd == CMD_TMPL) begin
      if (tpl_ok || tpl_cnt >= total) begin
        tpl_ok = 0;
        tpl_cnt = 0;
      end
      tpl_mem[tpl_cnt] = s.p.pixel;
      tpl_cnt++;
      if (tpl_cnt == total) begin
        tpl_sum = 0;
        tpl_sq = 0;
        for (int i = 0; i < total; i++) begin
          tpl_sum += tpl_mem[i];
          tpl_sq += longint'(tpl_mem[i]) * tpl_mem[i];
        end
        tpl_ok = 1;
      end
      return;
    end
    line_mem[(row_pos % 16) * 1024 + col_pos] = s.p.pixel;
    if (tpl_ok && row_pos + 1 >= th && col_pos + 1 >= tw) begin
      top = row_pos + 1 - th;
      left = col_pos + 1 - tw;
      sx = 0; sxx = 0; sxt = 0;
      for (m = 0; m < th; m++)
        for (k = 0; k < tw; k++) begin
          x = line_mem[((top + m) % 16) * 1024 + left + k];
          t = tpl_mem[m * tw + k];
          sx += x;
          sxx += x * x;
          sxt += x * t;
        end
      res.score = s.fixed ? s.sc : zncc(total, sx, sxx, sxt);
      res.win_row = top[9:0];
      res.win_col = left[9:0];
      res.frame_end = (row_pos + 1 == sh && col_pos + 1 == sw);
      score_q.push_back(res);
    end
    if (col_pos + 1 >= sw) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= sh) ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
  endtask

  task automatic flag_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // pixel sender; prediction taken at each accepted transfer
  always @(posedge clk) begin
    if (!rst) begin
      if (pix_valid && !pix_stall) predict_pixel(cur);
      if (pix_valid && pix_stall) begin
        // hold payload
      end else if (pix_q.size() > 0 && !(idle_on && $urandom_range(99) < 10)) begin
        cur = pix_q.pop_front();
        pix_valid <= 1'b1;
        pix_data <= cur.p;
      end else begin
        pix_valid <= 1'b0;
      end
    end
  end

  // score receiver and checker
  always @(posedge clk) begin
    score_t e;
    if (!rst) begin
      if (score_valid && !score_stall) begin
        scores_seen++;
        if (score_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected score %p", score_data));
        end else begin
          e = score_q.pop_front();
          if (score_data.score !== e.score)
            flag_mismatch($sformatf("score %0d exp %0d", score_data.score, e.score));
          if (score_data.win_row !== e.win_row)
            flag_mismatch($sformatf("win_row %0d exp %0d", score_data.win_row, e.win_row));
          if (score_data.win_col !== e.win_col)
            flag_mismatch($sformatf("win_col %0d exp %0d", score_data.win_col, e.win_col));
          if (score_data.frame_end !== e.frame_end)
            flag_mismatch($sformatf("frame_end %0b exp %0b", score_data.frame_end,
                                    e.frame_end));
        end
        if (scores_seen == 40 && !hold_done) begin
          hold_done = 1;
          hold_left = 2000;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        score_stall <= 1'b1;
      end else begin
        score_stall <= idle_on && ($urandom_range(99) < 10);
      end
    end
  end

  task automatic push_pix(logic cmd, logic [7:0] px, bit fixed = 0,
                          logic signed [15:0] sc = 0);
    stim_t s;
    s.p.cmd = cmd;
    s.p.pixel = px;
    s.fixed = fixed;
    s.sc = sc;
    pix_q.push_back(s);
    items_pushed++;
    idle_on = !(items_pushed > 700 && items_pushed < 1100);
  endtask

  task automatic wait_idle();
    wait (pix_q.size() == 0 && !pix_valid && score_q.size() == 0);
    repeat (320) @(posedge clk);
  endtask

  task automatic apb_write(logic [1:0] idx, logic [31:0] d);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_SRC_W:  sw = clamp_dim(d[10:0], 1024);
      REG_SRC_H:  sh = clamp_dim(d[10:0], 1024);
      REG_TMPL_W: tw = clamp_dim(d[4:0], 16);
      default:    th = clamp_dim(d[4:0], 16);
    endcase
    tpl_cnt = 0; tpl_ok = 0; row_pos = 0; col_pos = 0;
  endtask

  task automatic configure(int unsigned w, int unsigned h, int unsigned a, int unsigned b);
    wait_idle();
    apb_write(REG_TMPL_H, b);
    apb_write(REG_SRC_W, w);
    apb_write(REG_TMPL_W, a);
    apb_write(REG_SRC_H, h);
  endtask

  task automatic run_phase(int unsigned w, int unsigned h, int unsigned a, int unsigned b,
                           int nsrc);
    int unsigned n;
    bit flat;
    logic [7:0] fv;
    configure(w, h, a, b);
    n = tw * th;
    if ($urandom_range(99) < 10)
      repeat ($urandom_range(1, n)) push_pix(CMD_TMPL, 8'($urandom));
    flat = $urandom_range(99) < 10;
    fv = 8'($urandom);
    repeat (n) push_pix(CMD_TMPL, flat ? fv : 8'($urandom));
    repeat (nsrc) begin
      if ($urandom_range(99) < 4) push_pix(CMD_TMPL, 8'($urandom));
      else push_pix(CMD_SRC, ($urandom_range(99) < 10) ? 8'hFF : 8'($urandom));
    end
  endtask

  typedef struct { logic cmd; logic [7:0] px; bit fixed; int sc; } row_t;
  row_t dir_tab[24] = '{
    '{CMD_TMPL, 8'd0,   0, 0}, '{CMD_TMPL, 8'd255, 0, 0},
    '{CMD_TMPL, 8'd255, 0, 0}, '{CMD_TMPL, 8'd0,   0, 0},
    // identical window saturates at +1.0
    '{CMD_SRC, 8'd0,   0, 0}, '{CMD_SRC, 8'd255, 0, 0},
    '{CMD_SRC, 8'd255, 0, 0}, '{CMD_SRC, 8'd0,   1, 32767},
    // inverted window gives -1.0
    '{CMD_SRC, 8'd255, 0, 0}, '{CMD_SRC, 8'd0,   0, 0},
    '{CMD_SRC, 8'd0,   0, 0}, '{CMD_SRC, 8'd255, 1, -32768},
    // flat window: zero denominator
    '{CMD_SRC, 8'd7, 0, 0}, '{CMD_SRC, 8'd7, 0, 0},
    '{CMD_SRC, 8'd7, 0, 0}, '{CMD_SRC, 8'd7, 1, 0},
    // reload with a flat template
    '{CMD_TMPL, 8'd5, 0, 0}, '{CMD_TMPL, 8'd5, 0, 0},
    '{CMD_TMPL, 8'd5, 0, 0}, '{CMD_TMPL, 8'd5, 0, 0},
    '{CMD_SRC, 8'd0,   0, 0}, '{CMD_SRC, 8'd255, 0, 0},
    '{CMD_SRC, 8'd255, 0, 0}, '{CMD_SRC, 8'd0,   1, 0}
  };

  initial begin
    int guard;
    sw = 1024; sh = 1024; tw = 16; th = 16;
    tpl_cnt = 0; tpl_ok = 0; row_pos = 0; col_pos = 0; tpl_sum = 0; tpl_sq = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    configure(2, 2, 2, 2);
    foreach (dir_tab[i])
      push_pix(dir_tab[i].cmd, dir_tab[i].px, dir_tab[i].fixed, 16'(dir_tab[i].sc));
    run_phase(2047, 2, 31, 1, 40);
    run_phase(1, 1024, 1, 0, 30);
    run_phase(0, 0, 0, 0, 10);
    run_phase(3, 3, 5, 5, 20);
    run_phase(17, 17, 16, 16, 289);
    while (items_pushed < 1850)
      run_phase($urandom_range(1, 12), $urandom_range(1, 10), $urandom_range(1, 4),
                $urandom_range(1, 4), $urandom_range(20, 80));
    wait (pix_q.size() == 0 && !pix_valid);
    guard = 0;
    while (score_q.size() > 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (400) @(posedge clk);
    if (score_q.size() > 0) flag_mismatch("expected scores never arrived");
    if (errors == 0) $display("zncc_template_match_top_tb OK");
    else $display("zncc_template_match_top_tb NOT OK");
    $finish;
  end

  initial begin
    #40ms;
    $display("zncc_template_match_top_tb NOT OK");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/zncc_pkg.sv
design/zncc_template_match_top.sv
tb/sv/zncc_template_match_top_tb.sv
